// ----- design/tape_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_pkg
// Shared types and constants for the tree ancestor path minimum engine.
// ----------------------------------------------------------------------------
package tape_pkg;

  localparam int NODES     = 1024;
  localparam int LEVELS    = 10;
  localparam int NODE_W    = $clog2(NODES);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int TBL_AW    = LVL_W + NODE_W;
  localparam int TBL_DEPTH = 1 << TBL_AW;
  localparam int CAP_I     = ((1 << LEVELS) - 1) < (NODES - 1) ?
                             ((1 << LEVELS) - 1) : (NODES - 1);
  localparam logic [NODE_W-1:0]  DEPTH_CAP = NODE_W'(CAP_I);
  localparam logic signed [31:0] W_MAX     = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    K_ADD  = 2'd0,
    K_LCA  = 2'd1,
    K_PMIN = 2'd2,
    K_KTH  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [9:0]         steps;
    logic signed [31:0] weight;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] answer;
    logic               empty_path;
  } out_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]  anc;
    logic signed [31:0] wmin;
  } tbl_entry_t;

  function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ----- design/tape_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tape_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/tree_ancestor_path_min_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_ancestor_path_min_engine
// Binary-lifting tree engine: node loading, common ancestor, path minimum
// and kth ancestor queries.
// ----------------------------------------------------------------------------
// One item is worked at a time by a sequencer around two memories: a lifting
// table (ancestor and minimum weight per level and node, one port each way)
// and a depth table. Every step up costs one table read, so timing follows
// the read port. An add naming node 0 is ignored, a root add writes the
// sentinel row at every level, any other add fills level 0 from its parent
// and weight and each higher level from the level below. A kth ancestor
// query on node 0, or one whose steps exceed the depth, answers 0 with no
// climb, otherwise it climbs by the set bits of steps; common ancestor and
// path minimum on node 0 answer with no climb, end after the equal-depth
// climb when it already meets, and otherwise go on to the paired descent.
// A query can also wait for the output register to be taken. A finished
// result waits in an output register; the next item is taken while it waits.
// Node 0 is the sentinel (depth -1, ancestors 0, weight maximum) and is
// supplied by logic, so the memories need no clearing after reset. Rows of
// a node never added read as whatever the memory holds.
// ----------------------------------------------------------------------------
module tree_ancestor_path_min_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  tape_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output tape_pkg::out_item_t result
);
  import tape_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ROOT, S_ADEP, S_ARD, S_AWR,
    S_KDEP, S_QDA, S_QDB, S_UPRD, S_UPWR, S_UPEND,
    S_P2U, S_P2V, S_P2C, S_FU, S_FV, S_FC, S_OUT
  } state_t;

  state_t             state;
  logic [1:0]         kind;
  logic [NODE_W-1:0]  u, v;          // add: u is the climb node, v the new node
  logic [NODE_W-1:0]  diff, dcur, da;
  logic [LVL_W-1:0]   lvl;
  logic signed [31:0] best;
  logic               took;
  tbl_entry_t         tmp;
  logic signed [31:0] res_ans;
  logic               res_empty;
  logic               rd_zero;

  // memory ports
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  tbl_entry_t        tbl_wdata;
  logic [LVL_W-1:0]  tbl_rlvl;
  logic [NODE_W-1:0] tbl_rnode;
  logic [$bits(tbl_entry_t)-1:0] tbl_rdata;
  tbl_entry_t        tbl_rd;
  logic              dep_we;
  logic [NODE_W-1:0] dep_waddr, dep_wdata, dep_raddr, dep_rdata;

  tape_ram #(.WIDTH($bits(tbl_entry_t)), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr({tbl_rlvl, tbl_rnode}), .rdata(tbl_rdata)
  );

  tape_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_dep (
    .clk(clk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
    .raddr(dep_raddr), .rdata(dep_rdata)
  );

  // sentinel row for node 0
  always_comb begin
    if (rd_zero) begin
      tbl_rd.anc  = '0;
      tbl_rd.wmin = W_MAX;
    end else begin
      tbl_rd = tbl_entry_t'(tbl_rdata);
    end
  end

  logic [NODE_W:0]   dep_inc;
  logic [NODE_W-1:0] dep_sat;
  assign dep_inc = {1'b0, dep_rdata} + {{NODE_W{1'b0}}, 1'b1};
  assign dep_sat = (dep_inc > {1'b0, DEPTH_CAP}) ? DEPTH_CAP : dep_inc[NODE_W-1:0];

  assign item_ready = (state == S_IDLE);

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = {lvl, v};
    tbl_wdata = tmp;
    tbl_rlvl  = lvl;
    tbl_rnode = u;
    dep_we    = 1'b0;
    dep_waddr = v;
    dep_wdata = '0;
    dep_raddr = (item.kind == K_ADD) ? item.node_b : item.node_a;
    unique case (state)
      S_ROOT: begin
        tbl_we         = 1'b1;
        tbl_wdata.anc  = '0;
        tbl_wdata.wmin = W_MAX;
        dep_we         = (lvl == '0);
      end
      S_ADEP: begin
        dep_we         = 1'b1;
        dep_wdata      = dep_sat;
        tbl_we         = 1'b1;
        tbl_waddr      = {{LVL_W{1'b0}}, v};
        tbl_wdata.anc  = u;
        tbl_wdata.wmin = best;
      end
      S_ARD: tbl_rlvl = lvl - LVL_W'(1);
      S_AWR: begin
        tbl_we         = 1'b1;
        tbl_wdata.anc  = tbl_rd.anc;
        tbl_wdata.wmin = smin(best, tbl_rd.wmin);
      end
      S_QDA: dep_raddr = v;
      S_P2V: tbl_rnode = v;
      S_FU:  tbl_rlvl  = '0;
      S_FV: begin
        tbl_rlvl  = '0;
        tbl_rnode = v;
      end
      default: ;
    endcase
  end

  logic [NODE_W-1:0] db;
  assign db = dep_rdata;

  always_ff @(posedge clk) begin
    rd_zero <= (tbl_rnode == '0);
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // output register: loaded from the output step, cleared once taken
      if (state == S_OUT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (item_valid) begin
          kind <= item.kind;
          unique case (item.kind)
            K_ADD: begin
              v    <= item.node_a;
              u    <= item.node_b;
              best <= item.weight;
              lvl  <= '0;
              if (item.node_a == '0) state <= S_IDLE;
              else if (item.node_b == '0) state <= S_ROOT;
              else state <= S_ADEP;
            end
            K_KTH: begin
              u         <= item.node_a;
              diff      <= item.steps;
              res_empty <= 1'b0;
              if (item.node_a == '0) begin
                res_ans <= '0;
                state   <= S_OUT;
              end else begin
                state <= S_KDEP;
              end
            end
            default: begin
              u <= item.node_a;
              v <= item.node_b;
              if (item.node_a == '0 || item.node_b == '0) begin
                res_ans   <= (item.kind == K_PMIN) ? W_MAX : '0;
                res_empty <= (item.kind == K_PMIN);
                state     <= S_OUT;
              end else begin
                res_empty <= 1'b0;
                state     <= S_QDA;
              end
            end
          endcase
        end
        S_ROOT: begin
          if (lvl == LVL_W'(LEVELS - 1)) state <= S_IDLE;
          lvl <= lvl + LVL_W'(1);
        end
        S_ADEP: begin
          lvl   <= LVL_W'(1);
          state <= S_ARD;
        end
        S_ARD: state <= S_AWR;
        S_AWR: begin
          u    <= tbl_rd.anc;
          best <= smin(best, tbl_rd.wmin);
          lvl  <= lvl + LVL_W'(1);
          state <= (lvl == LVL_W'(LEVELS - 1)) ? S_IDLE : S_ARD;
        end
        S_KDEP: begin
          lvl  <= '0;
          took <= 1'b0;
          best <= W_MAX;
          if (diff > dep_rdata) begin
            res_ans <= '0;
            state   <= S_OUT;
          end else begin
            state <= S_UPRD;
          end
        end
        S_QDA: begin
          da    <= dep_rdata;
          state <= S_QDB;
        end
        S_QDB: begin
          if (da < db) begin
            u    <= v;
            v    <= u;
            diff <= db - da;
            dcur <= da;
          end else begin
            diff <= da - db;
            dcur <= db;
          end
          best  <= W_MAX;
          took  <= 1'b0;
          lvl   <= '0;
          state <= S_UPRD;
        end
        S_UPRD: begin
          if (diff[lvl]) state <= S_UPWR;
          else if (lvl == LVL_W'(LEVELS - 1)) state <= S_UPEND;
          else lvl <= lvl + LVL_W'(1);
        end
        S_UPWR: begin
          u    <= tbl_rd.anc;
          best <= smin(best, tbl_rd.wmin);
          took <= 1'b1;
          if (lvl == LVL_W'(LEVELS - 1)) begin
            state <= S_UPEND;
          end else begin
            lvl   <= lvl + LVL_W'(1);
            state <= S_UPRD;
          end
        end
        S_UPEND: begin
          if (kind == K_KTH) begin
            res_ans <= 32'(u);
            state   <= S_OUT;
          end else if (u == v) begin
            res_ans   <= (kind == K_PMIN) ? best : 32'(u);
            res_empty <= (kind == K_PMIN) && !took;
            state     <= S_OUT;
          end else begin
            lvl   <= LVL_W'(LEVELS - 1);
            state <= S_P2U;
          end
        end
        S_P2U: state <= S_P2V;
        S_P2V: begin
          tmp   <= tbl_rd;
          state <= S_P2C;
        end
        S_P2C: begin
          // climb both sides while their ancestors still differ
          if (tmp.anc != tbl_rd.anc) begin
            u    <= tmp.anc;
            v    <= tbl_rd.anc;
            best <= smin(best, smin(tmp.wmin, tbl_rd.wmin));
            took <= 1'b1;
            dcur <= dcur - (NODE_W'(1) << lvl);
          end
          if (lvl == '0) state <= S_FU;
          else begin
            lvl   <= lvl - LVL_W'(1);
            state <= S_P2U;
          end
        end
        S_FU: state <= S_FV;
        S_FV: begin
          tmp   <= tbl_rd;
          state <= S_FC;
        end
        S_FC: begin
          if (kind == K_LCA) begin
            res_ans <= 32'(tmp.anc);
          end else begin
            res_ans   <= smin(best, smin(tmp.wmin, tbl_rd.wmin));
            res_empty <= !(took || (dcur != '0));
          end
          state <= S_OUT;
        end
        S_OUT: if (!result_valid || result_ready) begin
          result.answer     <= res_ans;
          result.empty_path <= res_empty;
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // lifting table is written only while a node is being loaded
  a_tbl_we_add: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> (state == S_ROOT || state == S_ADEP || state == S_AWR))
    else $error("lifting table written outside an add");

  // depth written once per add, at its first write cycle
  a_dep_we_once: assert property (@(posedge clk) disable iff (rst)
    dep_we |-> ((state == S_ROOT && lvl == '0) || state == S_ADEP))
    else $error("depth table written at wrong step");

  // a result is produced only from the output step, never by an add
  a_res_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_OUT) && $past(kind != K_ADD))
    else $error("result raised outside the output step");

endmodule

// ----- bench/tb_tree_ancestor_path_min_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tree_ancestor_path_min_engine
// Self-checking bench for the binary-lifting tree engine: a queue-fed driver
// pushes add and query items, a local lifting-table predictor works out each
// expected answer, and a monitor compares every result against it in order.
// ----------------------------------------------------------------------------
module tb_tree_ancestor_path_min_engine;
  import tape_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  tree_ancestor_path_min_engine dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the lifting tables
  logic [9:0]         lift_anc [LEVELS][NODES];
  logic signed [31:0] lift_min [LEVELS][NODES];
  int                 depth_of [NODES];

  in_item_t  pending_items[$];
  out_item_t expected_answers[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        queries_sent = 0;
  int        adds_sent = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;   // stretch with no idling
  bit        hold_off = 1'b0;
  bit        stim_done = 1'b0;

  function automatic logic signed [31:0] lo(logic signed [31:0] a,
                                            logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic void tree_reset();
    for (int i = 0; i < LEVELS; i++) begin
      lift_anc[i][0] = '0;
      lift_min[i][0] = W_MAX;
    end
    depth_of[0] = -1;
  endfunction

  // apply one item to the tables; return 1 if a result is expected
  function automatic bit tree_apply(in_item_t it, output out_item_t res);
    int u, v, t, d, diff, cap;
    logic signed [31:0] best;
    bit took;
    res = '0;
    u = int'(it.node_a);
    v = int'(it.node_b);
    cap = CAP_I;
    if (kind_t'(it.kind) == K_ADD) begin
      if (u == 0) return 0;
      d = (v == 0) ? 0 : depth_of[v] + 1;
      if (d > cap) d = cap;
      if (d < 0) d = 0;
      depth_of[u] = d;
      lift_anc[0][u] = v[9:0];
      lift_min[0][u] = (v == 0) ? W_MAX : it.weight;
      for (int i = 1; i < LEVELS; i++) begin
        t = int'(lift_anc[i-1][u]);
        lift_anc[i][u] = lift_anc[i-1][t];
        lift_min[i][u] = lo(lift_min[i-1][u], lift_min[i-1][t]);
      end
      return 0;
    end
    case (kind_t'(it.kind))
      K_LCA, K_PMIN: begin
        best = W_MAX;
        took = 1'b0;
        if (u == 0 || v == 0) begin
          res.answer = (kind_t'(it.kind) == K_LCA) ? 0 : W_MAX;
          res.empty_path = (kind_t'(it.kind) == K_PMIN);
          return 1;
        end
        if (depth_of[u] < depth_of[v]) begin t = u; u = v; v = t; end
        diff = depth_of[u] - depth_of[v];
        for (int i = 0; i < LEVELS; i++)
          if ((diff >> i) & 1) begin
            best = lo(best, lift_min[i][u]);
            u = int'(lift_anc[i][u]);
            took = 1'b1;
          end
        if (u == v) begin
          res.answer = (kind_t'(it.kind) == K_LCA) ? u : best;
        end else begin
          for (int i = LEVELS - 1; i >= 0; i--)
            if (lift_anc[i][u] != lift_anc[i][v]) begin
              best = lo(best, lo(lift_min[i][u], lift_min[i][v]));
              u = int'(lift_anc[i][u]);
              v = int'(lift_anc[i][v]);
              took = 1'b1;
            end
          best = lo(best, lo(lift_min[0][u], lift_min[0][v]));
          if (depth_of[u] > 0 || depth_of[v] > 0) took = 1'b1;
          res.answer = (kind_t'(it.kind) == K_LCA) ? 32'(lift_anc[0][u]) : best;
        end
        res.empty_path = (kind_t'(it.kind) == K_PMIN) && !took;
      end
      default: begin
        if (u == 0 || int'(it.steps) > depth_of[u]) res.answer = 0;
        else begin
          for (int i = 0; i < LEVELS; i++)
            if (it.steps[i]) u = int'(lift_anc[i][u]);
          res.answer = u;
        end
      end
    endcase
    return 1;
  endfunction

  // stimulus builders; only loaded nodes are ever read
  // planning copy, updated at push time; the predictor runs in the driver
  bit planned [NODES];

  function automatic int pick_planned();
    int n;
    for (int tries = 0; tries < 400; tries++) begin
      n = $urandom_range(1, NODES - 1);
      if (planned[n]) return n;
    end
    return 0;
  endfunction

  function automatic logic signed [31:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return W_MAX;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic void push(kind_t k, int a, int b, int s, logic signed [31:0] w);
    in_item_t it;
    it.kind = k; it.node_a = a[9:0]; it.node_b = b[9:0];
    it.steps = s[9:0]; it.weight = w;
    if (k == K_ADD && a != 0) planned[a] = 1'b1;
    pending_items = {pending_items, it};
  endfunction

  function automatic void push_random_query();
    kind_t k;
    int a, b;
    k = kind_t'($urandom_range(1, 3));
    a = ($urandom_range(0, 19) == 0) ? 0 : pick_planned();
    b = ($urandom_range(0, 19) == 0) ? 0 : pick_planned();
    if ($urandom_range(0, 9) == 0) b = a;
    push(k, a, b, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(0, 12),
         $signed($urandom()));
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
    mismatches++;
  endtask

  // driver: the prediction happens at acceptance
  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst) begin
      if (item_valid && item_ready) begin
        if (tree_apply(item, exp_res)) begin
          expected_answers = {expected_answers, exp_res};
          queries_sent++;
        end else adds_sent++;
      end
      if (!(item_valid && !item_ready)) begin
        if (pending_items.size() > 0 && !hold_off &&
            (calm || $urandom_range(0, 99) >= 10)) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
          item.weight <= $signed($urandom());
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      result_ready <= calm || ($urandom_range(0, 99) >= 10);
      if (result_valid && result_ready) begin
        results_seen++;
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected result", result.answer, '0);
        end else begin
          want = expected_answers.pop_front();
          if (result.answer !== want.answer)
            report_mismatch("answer", result.answer, want.answer);
          if (result.empty_path !== want.empty_path)
            report_mismatch("empty_path", 32'(result.empty_path),
                            32'(want.empty_path));
        end
      end
    end
  end

  // watchdog on handshake inactivity
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready))
      idle_cycles <= 0;
    else if (pending_items.size() > 0 || expected_answers.size() > 0 ||
             item_valid) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t", $realtime);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic drain_all();
    while (pending_items.size() > 0 || item_valid || expected_answers.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int a, b, count;
    tree_reset();
    for (int n = 0; n < NODES; n++) planned[n] = (n == 0);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: chain 1..12, a root, separate tree, extremes and odd cases
    push(K_ADD, 1, 0, 0, 32'sh1234);                 // root, weight ignored
    for (int n = 2; n <= 12; n++)
      push(K_ADD, n, n - 1, 0, (n == 5) ? 32'sh8000_0000 : n * 7);
    push(K_ADD, 1023, 0, 0, W_MAX);                  // second root
    push(K_ADD, 1022, 1023, 1023, W_MAX);
    push(K_ADD, 0, 1, 0, 5);                          // add to sentinel, ignored
    push(K_LCA, 12, 7, 0, 0);
    push(K_LCA, 12, 1022, 0, 0);                      // separate trees
    push(K_PMIN, 12, 12, 0, 0);                       // empty path
    push(K_PMIN, 1, 1023, 0, 0);                      // two roots
    push(K_PMIN, 12, 3, 0, 0);
    push(K_PMIN, 12, 1022, 0, 0);
    push(K_PMIN, 0, 12, 0, 0);
    push(K_LCA, 5, 0, 0, 0);
    push(K_KTH, 12, 0, 11, 0);
    push(K_KTH, 12, 0, 12, 0);                        // past root
    push(K_KTH, 12, 0, 1023, 0);
    push(K_KTH, 0, 0, 0, 0);
    push(K_ADD, 7, 1023, 0, -1);                      // re-add moves a node
    push(K_PMIN, 7, 1022, 0, 0);
    drain_all();

    // pause until every result is in, then random phases
    hold_off = 1'b1;
    repeat (80) @(posedge clk);
    hold_off = 1'b0;

    count = 0;
    while (count < 1930) begin
      if (count > 600 && count < 800) calm = 1'b1;
      else calm = 1'b0;
      if ($urandom_range(0, 99) < 45) begin
        // mostly parent-first: parent loaded, or a new root
        a = $urandom_range(1, NODES - 1);
        b = ($urandom_range(0, 7) == 0) ? 0 : pick_planned();
        if ($urandom_range(0, 99) < 60) begin
          // prefer deepening the tree by chaining onto an already planned node
          b = pick_planned();
          if (b == a) b = 0;
        end
        if (a == b) b = 0;
        push(K_ADD, a, b, $urandom_range(0, 1023), rand_weight());
      end else push_random_query();
      count++;
      if (count % 200 == 0) drain_all();
    end
    drain_all();
    repeat (100) @(posedge clk);

    $display("covered %0d adds and %0d queries, %0d results checked",
             adds_sent, queries_sent, results_seen);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
